### rtl/twrtc_pkg.sv
// Package with the item types, request codes and helper functions of the three-wire serial master.
`timescale 1ns / 1ps

package twrtc_pkg;

  // Width of the bit-timing tick counter; the half period is capped at its largest count.
  localparam int TICK_COUNTER_WIDTH = 8;
  localparam int TICK_MAX           = (1 << TICK_COUNTER_WIDTH) - 1;

  localparam logic [7:0] HALF_PERIOD_RESET = 8'd2;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_SPARE = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t   req_type;
    logic [7:0]  command_byte;
    logic [7:0]  write_data;
    logic        data_pin_in;
  } req_item_t;

  typedef struct packed {
    logic        chip_enable;
    logic        serial_clock;
    logic        data_pin_out;
    logic        data_pin_drive;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  raw_read_byte;
    logic [7:0]  decimal_value;
    logic        rejected;
  } res_item_t;

  // A zero setting behaves as one; a setting beyond the counter range is capped.
  function automatic logic [TICK_COUNTER_WIDTH-1:0] eff_half(input logic [7:0] setting);
    logic [7:0] h;
    h = (setting == 8'd0) ? 8'd1 : setting;
    if (int'(h) > TICK_MAX) begin
      return TICK_COUNTER_WIDTH'(TICK_MAX);
    end
    return TICK_COUNTER_WIDTH'(h);
  endfunction

  // Low nibble plus ten times the high nibble, done with shifts and adds.
  function automatic logic [7:0] nibble_decimal(input logic [7:0] b);
    logic [7:0] hi;
    hi = {4'd0, b[7:4]};
    return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
  endfunction

endpackage

### rtl/twrtc_engine.sv
// Bit sequencer of the three-wire serial master: phase, bit timing and shift registers.
`timescale 1ns / 1ps

module twrtc_engine import twrtc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  req_item_t                     item,
  input  logic [TICK_COUNTER_WIDTH-1:0] half,
  output res_item_t                     res
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CMD,
    PH_WDATA,
    PH_RDATA
  } phase_t;

  phase_t                        phase, phase_next;
  logic [2:0]                    bit_position, bit_position_next;
  logic [TICK_COUNTER_WIDTH-1:0] tick_counter, tick_counter_next;
  logic                          clock_high_half, clock_high_half_next;
  logic [7:0]                    outgoing_shift, outgoing_shift_next;
  logic [7:0]                    pending_data, pending_data_next;
  logic [7:0]                    incoming_shift, incoming_shift_next;
  logic                          is_read, is_read_next;
  logic [7:0]                    last_read, last_read_next;
  logic                          is_req, start, low_tick, done, drive;

  always_comb begin
    phase_next           = phase;
    bit_position_next    = bit_position;
    tick_counter_next    = tick_counter;
    clock_high_half_next = clock_high_half;
    outgoing_shift_next  = outgoing_shift;
    pending_data_next    = pending_data;
    incoming_shift_next  = incoming_shift;
    is_read_next         = is_read;
    last_read_next       = last_read;
    low_tick             = 1'b0;
    done                 = 1'b0;

    is_req = (item.req_type == REQ_READ) || (item.req_type == REQ_WRITE);
    start  = is_req && (phase == PH_IDLE);

    if (start) begin
      phase_next           = PH_CMD;
      is_read_next         = (item.req_type == REQ_READ);
      outgoing_shift_next  = item.command_byte;
      pending_data_next    = item.write_data;
      incoming_shift_next  = 8'd0;
      bit_position_next    = 3'd0;
      clock_high_half_next = 1'b0;
      tick_counter_next    = half;
    end else if (phase != PH_IDLE) begin
      if (clock_high_half) begin
        if (tick_counter >= half) begin
          clock_high_half_next = 1'b0;
          tick_counter_next    = TICK_COUNTER_WIDTH'(1);
          low_tick             = 1'b1;
        end else begin
          tick_counter_next = tick_counter + 1'b1;
        end
      end else if (tick_counter >= half) begin
        // Rising edge of the serial clock: a read samples the line here.
        clock_high_half_next = 1'b1;
        tick_counter_next    = TICK_COUNTER_WIDTH'(1);
        if (phase == PH_RDATA) begin
          incoming_shift_next = {item.data_pin_in, incoming_shift[7:1]};
        end
      end else begin
        tick_counter_next = tick_counter + 1'b1;
        low_tick          = 1'b1;
      end

      if (low_tick && (tick_counter_next >= half)) begin
        if (bit_position != 3'd7) begin
          bit_position_next   = bit_position + 3'd1;
          outgoing_shift_next = {1'b0, outgoing_shift[7:1]};
        end else begin
          bit_position_next = 3'd0;
          if (phase == PH_CMD) begin
            if (is_read) begin
              phase_next          = PH_RDATA;
              incoming_shift_next = 8'd0;
            end else begin
              phase_next          = PH_WDATA;
              outgoing_shift_next = pending_data;
            end
          end else begin
            if (phase == PH_RDATA) begin
              last_read_next = incoming_shift_next;
            end
            phase_next           = PH_IDLE;
            clock_high_half_next = 1'b0;
            tick_counter_next    = '0;
            done                 = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    drive              = (phase_next == PH_CMD) || (phase_next == PH_WDATA);
    res.chip_enable    = (phase_next != PH_IDLE);
    res.serial_clock   = (phase_next != PH_IDLE) && clock_high_half_next;
    res.data_pin_out   = drive && outgoing_shift_next[0];
    res.data_pin_drive = drive;
    res.busy_res       = (phase_next != PH_IDLE);
    res.done_res       = done;
    res.raw_read_byte  = last_read_next;
    res.decimal_value  = nibble_decimal(last_read_next);
    res.rejected       = is_req && !start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bit_position    <= 3'd0;
      tick_counter    <= '0;
      clock_high_half <= 1'b0;
      outgoing_shift  <= 8'd0;
      pending_data    <= 8'd0;
      incoming_shift  <= 8'd0;
      is_read         <= 1'b0;
      last_read       <= 8'd0;
    end else if (fire) begin
      phase           <= phase_next;
      bit_position    <= bit_position_next;
      tick_counter    <= tick_counter_next;
      clock_high_half <= clock_high_half_next;
      outgoing_shift  <= outgoing_shift_next;
      pending_data    <= pending_data_next;
      incoming_shift  <= incoming_shift_next;
      is_read         <= is_read_next;
      last_read       <= last_read_next;
    end
  end

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    fire && res.done_res |=> phase == PH_IDLE)
    else $error("transaction finished but the sequencer did not return to idle");

  a_no_stray_step: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(phase) && $stable(tick_counter) && $stable(bit_position))
    else $error("sequencer state moved without an accepted transaction");

  a_reject_only_busy: assert property (@(posedge clk) disable iff (rst)
    fire && res.rejected |-> phase != PH_IDLE)
    else $error("request rejected while the sequencer was idle");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> !clock_high_half && tick_counter == '0)
    else $error("serial clock timing left active while idle");

endmodule

### rtl/three_wire_rtc_serial_master_core.sv
// Top level of the three-wire serial master: handshakes, half-period register, result register.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake            | Payload
// req      | in        | req_valid/req_ready  | req_item (req_item_t)
// res      | out       | res_valid/res_ready  | res_item (res_item_t)
// cfg      | in        | cfg_valid/cfg_ready  | cfg_data (half_period_ticks, 8 bits)
//
// Every request transaction is one tick of the bit timing and yields exactly one result
// transaction. The result of a taken transaction appears in the output register on the
// next cycle; while the result side does not stall, one transaction per cycle is
// sustained, set by the single registered pass through the sequencer. Reset is synchronous:
// the sequencer goes idle, the half period returns to two and the output register is emptied.
// When the result side stalls, the request side is held off only while the output register
// is full and not being read; the configuration channel is always ready.

module three_wire_rtc_serial_master_core import twrtc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  req_item_t  req_item,
  output logic       res_valid,
  input  logic       res_ready,
  output res_item_t  res_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [7:0]                    half_period_ticks;
  logic [TICK_COUNTER_WIDTH-1:0] half;
  logic                          req_fire;
  res_item_t                     res_next;

  // The output register is the only buffer: a new transaction is taken whenever it is
  // empty or is being emptied on this edge.
  assign req_ready = !res_valid || res_ready;
  assign req_fire  = req_valid && req_ready;
  assign cfg_ready = 1'b1;

  // A half period of zero counts as one, and is capped at the counter's largest count.
  assign half = eff_half(half_period_ticks);

  twrtc_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (req_fire),
    .item (req_item),
    .half (half),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PERIOD_RESET;
      res_valid         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        half_period_ticks <= cfg_data;
      end
      if (req_fire) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // The result payload needs no reset; it is loaded with every accepted transaction.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      res_item <= res_next;
    end
  end

  a_drive_gates_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.data_pin_out |-> res_item.data_pin_drive)
    else $error("data line level set while the line is released");

  a_clock_inside_enable: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.serial_clock |-> res_item.chip_enable)
    else $error("serial clock high outside a transaction");

  a_result_follows_take: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> res_valid)
    else $error("accepted transaction produced no result");

endmodule
